[hw/rtl/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared constants and the result record of the byte-stuffed frame deframer.
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam logic [7:0] START_BYTE  = 8'hFA;
  localparam logic [7:0] ESCAPE_BYTE = 8'hF9;
  localparam logic [7:0] ESCAPE_MASK = 8'h42;

  localparam int IDENT_W = 29;
  localparam int FLAGS_W = 3;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int FRAME_W = IDENT_W + FLAGS_W + LEN_W + DATA_W;
  // Result bus rounded up to whole bytes.
  localparam int OUT_TDATA_W = ((FRAME_W + 7) / 8) * 8;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [LEN_W-1:0]   len;
    logic [FLAGS_W-1:0] flags;
    logic [IDENT_W-1:0] ident;
  } frame_t;

endpackage

[hw/rtl/bsd_deframe_core.sv]
// ----------------------------------------------------------------------------
// bsd_deframe_core
// Per-byte unescape, frame parsing and checksum; holds the frame state.
// ----------------------------------------------------------------------------
module bsd_deframe_core #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic [7:0]     rx_byte,
  output logic           res_valid,
  output bsd_pkg::frame_t res_frame
);
  import bsd_pkg::*;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_ID0  = 4'd1;
  localparam logic [3:0] PH_LEN  = 4'd5;
  localparam logic [3:0] PH_DATA = 4'd6;
  localparam logic [7:0] LEN_MAX = 8'(MAX_DATA_BYTES + 1);

  logic [3:0] phase_r,  phase_nxt;
  logic       esc_r,    esc_nxt;
  logic [31:0] ident_r, ident_nxt;
  logic [7:0] xor_r,    xor_nxt;
  logic [3:0] count_r,  count_nxt;
  logic [7:0] store_r   [MAX_DATA_BYTES];
  logic [7:0] store_nxt [MAX_DATA_BYTES];

  logic [7:0] byte_c;
  logic [3:0] slot_c;
  logic       in_data_c;

  assign byte_c    = esc_r ? (rx_byte ^ ESCAPE_MASK) : rx_byte;
  assign slot_c    = phase_r - PH_DATA;
  assign in_data_c = {1'b0, phase_r} < ({1'b0, count_r} + {1'b0, PH_DATA});

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    ident_nxt = ident_r;
    xor_nxt   = xor_r;
    count_nxt = count_r;
    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
      store_nxt[i] = store_r[i];
    end
    res_valid = 1'b0;

    if (step_en) begin
      if (rx_byte == START_BYTE) begin
        esc_nxt   = 1'b0;
        ident_nxt = '0;
        xor_nxt   = '0;
        phase_nxt = PH_ID0;
      end else if (rx_byte == ESCAPE_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (phase_r == PH_IDLE) begin
          // drop bytes outside a frame
        end else if (phase_r < PH_LEN) begin
          for (int k = 0; k < 4; k++) begin
            if (phase_r == 4'(k + 1)) begin
              ident_nxt[8*(3-k) +: 8] = ident_r[8*(3-k) +: 8] | byte_c;
            end
          end
          xor_nxt   = xor_r ^ byte_c;
          phase_nxt = phase_r + 4'd1;
        end else if (phase_r == PH_LEN) begin
          if (byte_c == 8'd0 || byte_c > LEN_MAX) begin
            // bad length: restart identifier collection
            ident_nxt = '0;
            xor_nxt   = '0;
            phase_nxt = PH_ID0;
          end else begin
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
              store_nxt[i] = '0;
            end
            count_nxt = byte_c[3:0] - 4'd1;
            xor_nxt   = xor_r ^ byte_c;
            phase_nxt = PH_DATA;
          end
        end else if (in_data_c) begin
          for (int i = 0; i < MAX_DATA_BYTES; i++) begin
            if (slot_c == 4'(i)) begin
              store_nxt[i] = byte_c;
            end
          end
          xor_nxt   = xor_r ^ byte_c;
          phase_nxt = phase_r + 4'd1;
        end else begin
          // checksum position: emit on match, back to idle either way
          res_valid = (xor_r == byte_c);
          ident_nxt = '0;
          xor_nxt   = '0;
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      esc_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ident_r <= ident_nxt;
    xor_r   <= xor_nxt;
    count_r <= count_nxt;
    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
      store_r[i] <= store_nxt[i];
    end
  end

  assign res_frame.ident = ident_r[IDENT_W-1:0];
  assign res_frame.flags = ident_r[31:IDENT_W];
  assign res_frame.len   = count_r;

  for (genvar g = 0; g < 8; g++) begin : g_pack
    if (g < MAX_DATA_BYTES) begin : g_used
      assign res_frame.data[8*g +: 8] = store_r[g];
    end else begin : g_pad
      assign res_frame.data[8*g +: 8] = 8'd0;
    end
  end

  a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, phase_r} <= 5'(PH_DATA + MAX_DATA_BYTES))
    else $error("phase beyond checksum position");

  a_emit_idle : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (phase_r == PH_IDLE && !esc_r))
    else $error("emitted frame did not return to idle");

  a_start_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && rx_byte == START_BYTE) |=> (phase_r == PH_ID0 && !esc_r))
    else $error("start byte did not restart the frame");

  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (count_r < 4'(MAX_DATA_BYTES + 1)))
    else $error("emitted length above maximum");

endmodule

[hw/rtl/bsd_out_reg.sv]
// ----------------------------------------------------------------------------
// bsd_out_reg
// Result register: holds one finished frame until the receiver takes it.
// ----------------------------------------------------------------------------
module bsd_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  input  bsd_pkg::frame_t res_frame,
  input  logic            out_tready,
  output logic            out_tvalid,
  output bsd_pkg::frame_t out_frame,
  output logic            advance
);
  import bsd_pkg::*;

  logic   valid_r;
  frame_t frame_r;

  // free when empty or when the held frame leaves this cycle
  assign advance    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_frame  = frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      frame_r <= res_frame;
    end
  end

endmodule

[hw/rtl/byte_stuffed_can_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// byte_stuffed_can_frame_deframer_unit
// Recovers CAN-style frames from a byte-stuffed serial byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one raw line byte per transfer (in_tdata). 0xFA
//   starts a frame, 0xF9 escapes the following byte (XOR 0x42). A frame is a
//   big-endian 32-bit identifier word, a length byte L (1..MAX_DATA_BYTES+1,
//   giving L-1 data bytes), the data and an XOR checksum. A bad length
//   restarts identifier collection; a bad checksum drops the frame silently.
//   The out_ channel carries one transfer per good frame.
// Timing:
//   A byte lands in the input register at its transfer; the parser then works
//   on it once the result register can take its output and, at a good
//   checksum byte, loads the result register, which raises out_tvalid; the
//   result transfer can happen as soon as out_tvalid is high.
//   One byte per cycle is sustained while no result waits on out_tready; the
//   parser is a single short step per byte between input and result registers.
// Stall:
//   While a result waits on out_tready, the input register takes one more
//   byte only if it is empty; in_tready then stays low until the result leaves.
// Reset:
//   rst_n (synchronous, active low) empties both registers and returns the
//   parser to idle with no escape pending.
// ----------------------------------------------------------------------------
module byte_stuffed_can_frame_deframer_unit #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,
  // out_tdata: [28:0] frame_ident, [31:29] frame_flags, [35:32] frame_len,
  //            [99:36] frame_data, [103:100] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bsd_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import bsd_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       step_en;
  logic       res_valid;
  frame_t     res_frame;
  frame_t     out_frame;

  // Take a new byte whenever the input register is empty or moves on.
  assign in_tready = !in_v_r || advance;
  // Advance the parser only when the result register can take its output.
  assign step_en   = in_v_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // Hold the payload; no reset needed.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  bsd_deframe_core #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res_frame (res_frame)
  );

  bsd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_frame  (res_frame),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_frame  (out_frame),
    .advance    (advance)
  );

  // Pad the packed frame up to whole bytes with zeros.
  assign out_tdata = {{(OUT_TDATA_W - FRAME_W){1'b0}}, out_frame};

endmodule
